// ===== rtl/core/sogi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sogi_pkg: shared constants, types and helpers for the grid sync unit
// Fixed-point helpers (rounding shift, saturation) and the quarter-wave
// sine table, built at elaboration.
// ----------------------------------------------------------------------------
package sogi_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int IO_SHIFT        = 31 - SAMPLE_BITS;
  localparam int ROM_N           = 1 << SINE_TABLE_BITS;
  localparam int ROM_HALF        = ROM_N >> 1;
  localparam int ROM_AW          = SINE_TABLE_BITS + 1;
  localparam int OP_W            = 33;
  localparam int PROD_W          = 2 * OP_W;
  localparam int SUM_W           = PROD_W + 1;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam logic signed [OP_W-1:0] TWO_OVER_PI_Q32 = 33'sh0A2F9836E;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_INTEG_MAX   = 3'd2,
    REG_INTEG_MIN   = 3'd3,
    REG_NOMINAL     = 3'd4,
    REG_COEF_A      = 3'd5,
    REG_COEF_B      = 3'd6,
    REG_OFFSET_MODE = 3'd7
  } reg_idx_t;

  typedef logic [15:0] rom_t [ROM_N+1];

  // shift and subtract quotient of two non-negative values, table build only
  function automatic longint udiv(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem <<< 1) | ((num >>> i) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  // taylor series sine over a quarter wave, scaled to 32767
  function automatic rom_t build_rom();
    rom_t   r;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    for (int k = 0; k <= ROM_N; k++) begin
      x    = (HALF_PI_Q30 * longint'(k) + longint'(ROM_HALF)) >>> SINE_TABLE_BITS;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2) >>> 30;
        term = udiv(term, longint'((2 * n) * (2 * n + 1)));
        sum  = ((n & 1) != 0) ? sum - term : sum + term;
      end
      if (sum < 0) sum = 0;
      v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      r[k] = 16'(v);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  // sign extend a 32-bit word to the sum width
  function automatic logic signed [SUM_W-1:0] ext32(input logic [31:0] v);
    return {{(SUM_W-32){v[31]}}, v};
  endfunction

  // round half up, then arithmetic shift right
  function automatic logic signed [SUM_W-1:0] rnd_shift(input logic signed [SUM_W-1:0] v,
                                                        input int n);
    logic signed [SUM_W-1:0] h;
    h = SUM_W'(1) << (n - 1);
    return (v + h) >>> n;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32'h7FFF_FFFF);
    lo = -hi - SUM_W'(1);
    if (v > hi) return 32'h7FFF_FFFF;
    if (v < lo) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = (SUM_W'(1) << (SAMPLE_BITS - 1)) - SUM_W'(1);
    lo = -hi - SUM_W'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sogi_pll_grid_sync_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sogi_pll_grid_sync_unit: single-phase SOGI PLL grid synchronizer
// One sample in, one result out; SOGI, offset filter, Park transform, PI
// loop and phase/sine update run on one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | in_grid_sample
//  out     | out_valid | out_stall | out_alpha_out .. out_rotated_sin
//  cfg     | cfg_we    | -         | cfg_index, cfg_wdata
//
// each request runs a sequence of dependent multiplies through the single
// registered multiplier. in_stall is high while a request is in work; the
// next request may enter while a result still waits. the last step holds
// while out_stall keeps an earlier result. reset is synchronous and returns
// cos to 32767, loop state, config and out_valid to 0; data regs not reset.
module sogi_pll_grid_sync_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [31:0]                         cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [sogi_pkg::SAMPLE_BITS-1:0]    in_grid_sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [sogi_pkg::SAMPLE_BITS-1:0]         out_alpha_out,
  output logic [sogi_pkg::SAMPLE_BITS-1:0]         out_beta_out,
  output logic [sogi_pkg::SAMPLE_BITS-1:0]         out_d_out,
  output logic [sogi_pkg::SAMPLE_BITS-1:0]         out_q_out,
  output logic [31:0]                              out_phase_out,
  output logic [31:0]                              out_freq_step_out,
  output logic [sogi_pkg::SAMPLE_BITS-1:0]         out_rotated_cos,
  output logic [sogi_pkg::SAMPLE_BITS-1:0]         out_rotated_sin
);

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_NA_MUL, S_NA, S_NB_MUL, S_NB, S_FA_MUL, S_FB_MUL,
    S_FILT, S_VB, S_D0, S_D1, S_D2, S_Q1, S_Q2, S_I0, S_I1, S_PI, S_OM,
    S_PH0, S_PH1, S_ROMA, S_ROMB, S_R0, S_R1, S_R2, S_R3, S_R4
  } state_t;

  state_t state_r;

  // configuration
  logic [31:0] prop_gain_r, integ_gain_r, integ_max_r, integ_min_r;
  logic [31:0] nominal_r, coef_a_r, coef_b_r;
  logic        offset_mode_r;

  // loop state
  logic [31:0] prev_error_r, alpha_r, beta_r, oip_r, off_est_r;
  logic [31:0] integ_r, phase_r, step_width_r;
  logic [15:0] cos_r, sin_r;

  // per-request working registers
  logic [31:0] x_r, e_r, na_r, nb_r, u_r, ya_r, vb_r, d_r, q_r, pi_r, omega_r;
  logic [15:0] ra_r;
  logic [sogi_pkg::SAMPLE_BITS-1:0] rcos_r;

  // shared multiplier and accumulator
  logic signed [sogi_pkg::OP_W-1:0]   mul_a, mul_b;
  logic signed [sogi_pkg::PROD_W-1:0] prod_r, acc_r;
  logic signed [sogi_pkg::SUM_W-1:0]  prod_x, acc_x;

  // table port
  logic [sogi_pkg::ROM_AW-1:0]          rom_addr;
  logic [15:0]                          rom_q;
  logic [sogi_pkg::SINE_TABLE_BITS-1:0] tab_idx;
  logic [1:0]                           quad;

  // datapath temporaries
  logic [31:0] y_c, integ_c, t_c;
  logic [15:0] sn_c, c_c;
  logic signed [sogi_pkg::SUM_W-1:0] dphase_c;

  assign in_stall = (state_r != S_IDLE);
  assign prod_x   = {prod_r[sogi_pkg::PROD_W-1], prod_r};
  assign acc_x    = {acc_r[sogi_pkg::PROD_W-1], acc_r};
  assign tab_idx  = phase_r[29:30-sogi_pkg::SINE_TABLE_BITS];
  assign quad     = phase_r[31:30];
  assign dphase_c = sogi_pkg::rnd_shift(prod_x, 32);

  // single read of the quarter-wave table
  always_comb begin
    rom_addr = (state_r == S_ROMA) ? {1'b0, tab_idx}
                                   : sogi_pkg::ROM_AW'(sogi_pkg::ROM_N) - {1'b0, tab_idx};
    rom_q = sogi_pkg::SINE_ROM[rom_addr];
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    t_c   = '0;
    unique case (state_r)
      S_NA_MUL: begin
        mul_a = {step_width_r[31], step_width_r};
        t_c   = sogi_pkg::sat32(sogi_pkg::ext32(e_r) + sogi_pkg::ext32(prev_error_r));
        mul_b = {t_c[31], t_c};
      end
      S_NB_MUL: begin
        mul_a = {step_width_r[31], step_width_r};
        t_c   = sogi_pkg::sat32(sogi_pkg::ext32(na_r) + sogi_pkg::ext32(alpha_r));
        mul_b = {t_c[31], t_c};
      end
      S_FA_MUL: begin
        mul_a = {coef_a_r[31], coef_a_r};
        t_c   = sogi_pkg::sat32(sogi_pkg::ext32(u_r) + sogi_pkg::ext32(oip_r));
        mul_b = {t_c[31], t_c};
      end
      S_FB_MUL: begin
        mul_a = {coef_b_r[31], coef_b_r};
        mul_b = {off_est_r[31], off_est_r};
      end
      S_D0: begin
        mul_a = {na_r[31], na_r};
        mul_b = {{17{cos_r[15]}}, cos_r};
      end
      S_D1: begin
        mul_a = {vb_r[31], vb_r};
        mul_b = {{17{sin_r[15]}}, sin_r};
      end
      S_D2: begin
        mul_a = {vb_r[31], vb_r};
        mul_b = {{17{cos_r[15]}}, cos_r};
      end
      S_Q1: begin
        mul_a = {na_r[31], na_r};
        mul_b = {{17{sin_r[15]}}, sin_r};
      end
      S_I0: begin
        mul_a = {integ_gain_r[31], integ_gain_r};
        mul_b = {q_r[31], q_r};
      end
      S_I1: begin
        mul_a = {prop_gain_r[31], prop_gain_r};
        mul_b = {q_r[31], q_r};
      end
      S_PH0: begin
        mul_a = {omega_r[31], omega_r};
        mul_b = sogi_pkg::TWO_OVER_PI_Q32;
      end
      S_R0: begin
        mul_a = {d_r[31], d_r};
        mul_b = {{17{cos_r[15]}}, cos_r};
      end
      S_R1: begin
        mul_a = {q_r[31], q_r};
        mul_b = {{17{sin_r[15]}}, sin_r};
      end
      S_R2: begin
        mul_a = {d_r[31], d_r};
        mul_b = {{17{sin_r[15]}}, sin_r};
      end
      // last product stays selected while the result waits
      S_R3, S_R4: begin
        mul_a = {q_r[31], q_r};
        mul_b = {{17{cos_r[15]}}, cos_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // filter output, clamped integrator and new angle
  always_comb begin
    y_c = sogi_pkg::sat32(sogi_pkg::ext32(ya_r)
                          + sogi_pkg::ext32(sogi_pkg::sat32(sogi_pkg::rnd_shift(prod_x, 30))));
    integ_c = sogi_pkg::sat32(sogi_pkg::ext32(integ_r)
                + sogi_pkg::ext32(sogi_pkg::sat32(sogi_pkg::rnd_shift(prod_x, 24))));
    if ($signed(integ_c) > $signed(integ_max_r)) integ_c = integ_max_r;
    if ($signed(integ_c) < $signed(integ_min_r)) integ_c = integ_min_r;
    unique case (quad)
      2'd0: begin sn_c = ra_r;   c_c = rom_q;  end
      2'd1: begin sn_c = rom_q;  c_c = -ra_r;  end
      2'd2: begin sn_c = -ra_r;  c_c = -rom_q; end
      2'd3: begin sn_c = -rom_q; c_c = ra_r;   end
    endcase
  end

  // sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid     <= 1'b0;
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      integ_max_r   <= '0;
      integ_min_r   <= '0;
      nominal_r     <= '0;
      coef_a_r      <= '0;
      coef_b_r      <= '0;
      offset_mode_r <= 1'b0;
      prev_error_r  <= '0;
      alpha_r       <= '0;
      beta_r        <= '0;
      oip_r         <= '0;
      off_est_r     <= '0;
      integ_r       <= '0;
      phase_r       <= '0;
      step_width_r  <= '0;
      cos_r         <= 16'sd32767;
      sin_r         <= '0;
    end else begin
      if (out_valid && !out_stall && state_r != S_R4) out_valid <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        unique case (sogi_pkg::reg_idx_t'(cfg_index))
          sogi_pkg::REG_PROP_GAIN:   prop_gain_r   <= cfg_wdata;
          sogi_pkg::REG_INTEG_GAIN:  integ_gain_r  <= cfg_wdata;
          sogi_pkg::REG_INTEG_MAX:   integ_max_r   <= cfg_wdata;
          sogi_pkg::REG_INTEG_MIN:   integ_min_r   <= cfg_wdata;
          sogi_pkg::REG_NOMINAL:     nominal_r     <= cfg_wdata;
          sogi_pkg::REG_COEF_A:      coef_a_r      <= cfg_wdata;
          sogi_pkg::REG_COEF_B:      coef_b_r      <= cfg_wdata;
          sogi_pkg::REG_OFFSET_MODE: offset_mode_r <= cfg_wdata[0];
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r     <= {{(32-sogi_pkg::SAMPLE_BITS){in_grid_sample[sogi_pkg::SAMPLE_BITS-1]}},
                        in_grid_sample} << sogi_pkg::IO_SHIFT;
            state_r <= S_ERR;
          end
        end
        // sogi error
        S_ERR: begin
          e_r <= sogi_pkg::sat32(sogi_pkg::ext32(x_r) - sogi_pkg::ext32(alpha_r)
                                 - sogi_pkg::ext32(beta_r));
          state_r <= S_NA_MUL;
        end
        S_NA_MUL: state_r <= S_NA;
        S_NA: begin
          na_r <= sogi_pkg::sat32(sogi_pkg::ext32(sogi_pkg::sat32(sogi_pkg::rnd_shift(prod_x, 31)))
                                  + sogi_pkg::ext32(alpha_r));
          state_r <= S_NB_MUL;
        end
        S_NB_MUL: state_r <= S_NB;
        S_NB: begin
          nb_r <= sogi_pkg::sat32(sogi_pkg::ext32(sogi_pkg::sat32(sogi_pkg::rnd_shift(prod_x, 31)))
                                  + sogi_pkg::ext32(beta_r));
          u_r  <= sogi_pkg::sat32(sogi_pkg::ext32(x_r) - sogi_pkg::ext32(na_r));
          state_r <= S_FA_MUL;
        end
        // offset filter
        S_FA_MUL: state_r <= S_FB_MUL;
        S_FB_MUL: begin
          ya_r    <= sogi_pkg::sat32(sogi_pkg::rnd_shift(prod_x, 30));
          state_r <= S_FILT;
        end
        S_FILT: begin
          oip_r     <= u_r;
          off_est_r <= y_c;
          state_r   <= S_VB;
        end
        S_VB: begin
          vb_r <= offset_mode_r ? nb_r
                  : sogi_pkg::sat32(sogi_pkg::ext32(nb_r) - sogi_pkg::ext32(off_est_r));
          state_r <= S_D0;
        end
        // park transform, two products per axis
        S_D0: state_r <= S_D1;
        S_D1: begin
          acc_r   <= prod_r;
          state_r <= S_D2;
        end
        S_D2: begin
          d_r     <= sogi_pkg::sat32(sogi_pkg::rnd_shift(acc_x + prod_x, 15));
          state_r <= S_Q1;
        end
        S_Q1: begin
          acc_r   <= prod_r;
          state_r <= S_Q2;
        end
        S_Q2: begin
          q_r     <= sogi_pkg::sat32(sogi_pkg::rnd_shift(acc_x - prod_x, 15));
          state_r <= S_I0;
        end
        // pi loop
        S_I0: state_r <= S_I1;
        S_I1: begin
          integ_r <= integ_c;
          state_r <= S_PI;
        end
        S_PI: begin
          pi_r <= sogi_pkg::sat32(sogi_pkg::ext32(sogi_pkg::sat32(sogi_pkg::rnd_shift(prod_x, 24)))
                                  + sogi_pkg::ext32(integ_r));
          state_r <= S_OM;
        end
        S_OM: begin
          omega_r <= sogi_pkg::sat32(sogi_pkg::ext32(nominal_r) + sogi_pkg::ext32(pi_r));
          state_r <= S_PH0;
        end
        // phase advance and table lookup
        S_PH0: state_r <= S_PH1;
        S_PH1: begin
          phase_r <= phase_r + dphase_c[31:0];
          state_r <= S_ROMA;
        end
        S_ROMA: begin
          ra_r    <= rom_q;
          state_r <= S_ROMB;
        end
        S_ROMB: begin
          sin_r   <= sn_c;
          cos_r   <= c_c;
          state_r <= S_R0;
        end
        // rotated outputs with the new angle
        S_R0: state_r <= S_R1;
        S_R1: begin
          acc_r   <= prod_r;
          state_r <= S_R2;
        end
        S_R2: begin
          rcos_r  <= sogi_pkg::sat_out(sogi_pkg::rnd_shift(acc_x - prod_x,
                                                           15 + sogi_pkg::IO_SHIFT));
          state_r <= S_R3;
        end
        S_R3: begin
          acc_r   <= prod_r;
          state_r <= S_R4;
        end
        S_R4: begin
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            out_alpha_out     <= sogi_pkg::sat_out(sogi_pkg::rnd_shift(sogi_pkg::ext32(na_r),
                                                                       sogi_pkg::IO_SHIFT));
            out_beta_out      <= sogi_pkg::sat_out(sogi_pkg::rnd_shift(sogi_pkg::ext32(vb_r),
                                                                       sogi_pkg::IO_SHIFT));
            out_d_out         <= sogi_pkg::sat_out(sogi_pkg::rnd_shift(sogi_pkg::ext32(d_r),
                                                                       sogi_pkg::IO_SHIFT));
            out_q_out         <= sogi_pkg::sat_out(sogi_pkg::rnd_shift(sogi_pkg::ext32(q_r),
                                                                       sogi_pkg::IO_SHIFT));
            out_phase_out     <= phase_r;
            out_freq_step_out <= omega_r;
            out_rotated_cos   <= rcos_r;
            out_rotated_sin   <= sogi_pkg::sat_out(sogi_pkg::rnd_shift(acc_x + prod_x,
                                                            15 + sogi_pkg::IO_SHIFT));
            prev_error_r      <= e_r;
            alpha_r           <= na_r;
            beta_r            <= nb_r;
            step_width_r      <= omega_r;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // a taken request keeps the input stalled on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a request was taken");

  // a result appears only out of the last sequencer step
  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_R4))
    else $error("result raised outside the last step");

  // phase moves only in the phase update step
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(state_r == S_PH1) |-> $stable(phase_r))
    else $error("phase changed outside its update step");

endmodule
`default_nettype wire

// ===== tb/sogi_pll_grid_sync_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sogi_pll_grid_sync_unit_checker: result checker for the grid sync unit
// Watches the configuration port and both channels, runs its own fixed-point
// model of the loop for each accepted request and compares every result.
// ----------------------------------------------------------------------------
module sogi_pll_grid_sync_unit_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [15:0] in_grid_sample,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] out_alpha_out,
  input  wire logic [15:0] out_beta_out,
  input  wire logic [15:0] out_d_out,
  input  wire logic [15:0] out_q_out,
  input  wire logic [31:0] out_phase_out,
  input  wire logic [31:0] out_freq_step_out,
  input  wire logic [15:0] out_rotated_cos,
  input  wire logic [15:0] out_rotated_sin,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [15:0] alpha;
    logic [15:0] beta;
    logic [15:0] d;
    logic [15:0] q;
    logic [31:0] phase;
    logic [31:0] freq;
    logic [15:0] rcos;
    logic [15:0] rsin;
  } grid_result_t;

  grid_result_t expected_results[$];
  longint sine_lut[sogi_pkg::ROM_N+1];

  // loop settings
  int kp, ki, imax, imin, nom, coef_a, coef_b;
  bit raw_beta;
  // loop state
  int err_z, alpha_z, beta_z, ofs_in_z, ofs_est, integ, wstep;
  int unsigned phase_acc;
  longint cos_z, sin_z;

  function automatic longint rshift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic int fmul(int a, int b, int sh);
    return clip32(rshift(longint'(a) * longint'(b), sh));
  endfunction

  // quarter-wave sine table from its series expansion
  initial begin
    longint x, x2, term, acc, v;
    for (int k = 0; k <= sogi_pkg::ROM_N; k++) begin
      x = (64'sd1686629713 * k + sogi_pkg::ROM_N / 2) >>> sogi_pkg::SINE_TABLE_BITS;
      x2 = (x * x) >>> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 10; n++) begin
        term = (term * x2) >>> 30;
        term = term / ((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - term : acc + term;
      end
      if (acc < 0) acc = 0;
      v = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      sine_lut[k] = v;
    end
  end

  function automatic grid_result_t predict_sync(logic [15:0] smp);
    grid_result_t r;
    int x, e, na, nb, u, y, vb, d, q, piv, om;
    longint c, sn, dl;
    int unsigned quad, idx;
    x = int'(longint'($signed(smp)) * (64'sd1 <<< sogi_pkg::IO_SHIFT));
    e = clip32(longint'(x) - alpha_z - beta_z);
    na = clip32(longint'(fmul(wstep, clip32(longint'(e) + err_z), 31)) + alpha_z);
    nb = clip32(longint'(fmul(wstep, clip32(longint'(na) + alpha_z), 31)) + beta_z);
    u = clip32(longint'(x) - na);
    y = clip32(longint'(fmul(coef_a, clip32(longint'(u) + ofs_in_z), 30))
               + fmul(coef_b, ofs_est, 30));
    ofs_in_z = u;
    ofs_est = y;
    vb = raw_beta ? nb : clip32(longint'(nb) - y);
    d = clip32(rshift(longint'(na) * cos_z + longint'(vb) * sin_z, 15));
    q = clip32(rshift(longint'(vb) * cos_z - longint'(na) * sin_z, 15));
    integ = clip32(longint'(integ) + fmul(ki, q, 24));
    if (integ > imax) integ = imax;
    if (integ < imin) integ = imin;
    piv = clip32(longint'(fmul(kp, q, 24)) + integ);
    om = clip32(longint'(nom) + piv);
    dl = rshift(longint'(om) * 64'sd2734261102, 32);
    phase_acc = phase_acc + dl[31:0];
    quad = phase_acc >> 30;
    idx = (phase_acc >> (30 - sogi_pkg::SINE_TABLE_BITS)) & (sogi_pkg::ROM_N - 1);
    case (quad)
      0: begin sn = sine_lut[idx]; c = sine_lut[sogi_pkg::ROM_N - idx]; end
      1: begin sn = sine_lut[sogi_pkg::ROM_N - idx]; c = -sine_lut[idx]; end
      2: begin sn = -sine_lut[idx]; c = -sine_lut[sogi_pkg::ROM_N - idx]; end
      default: begin sn = -sine_lut[sogi_pkg::ROM_N - idx]; c = sine_lut[idx]; end
    endcase
    r.alpha = clip16(rshift(na, sogi_pkg::IO_SHIFT));
    r.beta = clip16(rshift(vb, sogi_pkg::IO_SHIFT));
    r.d = clip16(rshift(d, sogi_pkg::IO_SHIFT));
    r.q = clip16(rshift(q, sogi_pkg::IO_SHIFT));
    r.phase = phase_acc;
    r.freq = om;
    r.rcos = clip16(rshift(longint'(d) * c - longint'(q) * sn, 15 + sogi_pkg::IO_SHIFT));
    r.rsin = clip16(rshift(longint'(d) * sn + longint'(q) * c, 15 + sogi_pkg::IO_SHIFT));
    err_z = e;
    alpha_z = na;
    beta_z = nb;
    wstep = om;
    cos_z = c;
    sin_z = sn;
    return r;
  endfunction

  task automatic cmp_field(string nm, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %h actual %h", $time, nm, exp_v, act_v);
      fail_count++;
    end
  endtask

  // track configuration, predict accepted requests, check results
  always @(posedge clk) begin
    grid_result_t exp_r;
    if (!rst_n) begin
      raw_beta = 0;
      err_z = 0; alpha_z = 0; beta_z = 0; ofs_in_z = 0; ofs_est = 0;
      integ = 0; wstep = 0; phase_acc = 0; cos_z = 32767; sin_z = 0;
      kp = 0; ki = 0; imax = 0; imin = 0; nom = 0; coef_a = 0; coef_b = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (sogi_pkg::reg_idx_t'(cfg_index))
          sogi_pkg::REG_PROP_GAIN:   kp = cfg_wdata;
          sogi_pkg::REG_INTEG_GAIN:  ki = cfg_wdata;
          sogi_pkg::REG_INTEG_MAX:   imax = cfg_wdata;
          sogi_pkg::REG_INTEG_MIN:   imin = cfg_wdata;
          sogi_pkg::REG_NOMINAL:     nom = cfg_wdata;
          sogi_pkg::REG_COEF_A:      coef_a = cfg_wdata;
          sogi_pkg::REG_COEF_B:      coef_b = cfg_wdata;
          sogi_pkg::REG_OFFSET_MODE: raw_beta = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result phase %h", $time, out_phase_out);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          cmp_field("alpha", exp_r.alpha, out_alpha_out);
          cmp_field("beta", exp_r.beta, out_beta_out);
          cmp_field("d", exp_r.d, out_d_out);
          cmp_field("q", exp_r.q, out_q_out);
          cmp_field("phase", exp_r.phase, out_phase_out);
          cmp_field("freq_step", exp_r.freq, out_freq_step_out);
          cmp_field("rotated_cos", exp_r.rcos, out_rotated_cos);
          cmp_field("rotated_sin", exp_r.rsin, out_rotated_sin);
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_sync(in_grid_sample));
    end
    pending = expected_results.size();
  end

  initial fail_count = 0;
endmodule

// ===== tb/sogi_pll_grid_sync_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sogi_pll_grid_sync_unit_test: top level bench for the grid sync unit
// Drives grid samples through several loop settings, with random gaps on
// both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module sogi_pll_grid_sync_unit_test;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [15:0] in_grid_sample = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_alpha_out, out_beta_out, out_d_out, out_q_out;
  logic [31:0] out_phase_out, out_freq_step_out;
  logic [15:0] out_rotated_cos, out_rotated_sin;
  int          fail_count;
  int          pending;
  bit          stall_on = 1;

  sogi_pll_grid_sync_unit dut (.*);
  sogi_pll_grid_sync_unit_checker chk (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  // receiver back-pressure, with quiet stretches
  always @(negedge clk) begin
    if (!stall_on) out_stall <= 0;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1;
    else if (out_stall && $urandom_range(0, 3) == 0) out_stall <= 0;
  end

  task automatic write_reg(sogi_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // the request is taken at a rising edge while in_stall is low
  task automatic send_sample(logic [15:0] smp);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 0;
      in_grid_sample <= $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_grid_sample <= smp;
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // one loop setting per phase
  task automatic apply_setting(int kind);
    case (kind)
      0: begin // typical locking setup near 50 Hz at 20 kHz
        write_reg(sogi_pkg::REG_PROP_GAIN, 32'sd16777216 / 4);
        write_reg(sogi_pkg::REG_INTEG_GAIN, 32'sd20000);
        write_reg(sogi_pkg::REG_INTEG_MAX, 32'sd30000000);
        write_reg(sogi_pkg::REG_INTEG_MIN, -32'sd30000000);
        write_reg(sogi_pkg::REG_NOMINAL, 32'sd16864298);
        write_reg(sogi_pkg::REG_COEF_A, 32'sd5000000);
        write_reg(sogi_pkg::REG_COEF_B, 32'sd1063741824);
        write_reg(sogi_pkg::REG_OFFSET_MODE, 32'd0);
      end
      1: begin // extremes, crossed clamps, raw beta
        write_reg(sogi_pkg::REG_PROP_GAIN, 32'h7FFFFFFF);
        write_reg(sogi_pkg::REG_INTEG_GAIN, 32'h80000000);
        write_reg(sogi_pkg::REG_INTEG_MAX, 32'h80000000);
        write_reg(sogi_pkg::REG_INTEG_MIN, 32'h7FFFFFFF);
        write_reg(sogi_pkg::REG_NOMINAL, 32'h7FFFFFFF);
        write_reg(sogi_pkg::REG_COEF_A, 32'h80000000);
        write_reg(sogi_pkg::REG_COEF_B, 32'h7FFFFFFF);
        write_reg(sogi_pkg::REG_OFFSET_MODE, 32'hFFFFFFFF);
      end
      default: begin
        for (int i = 0; i < 7; i++) write_reg(sogi_pkg::reg_idx_t'(i), $urandom);
        write_reg(sogi_pkg::REG_OFFSET_MODE, $urandom);
      end
    endcase
  endtask

  initial begin
    int ph;
    repeat (9) @(negedge clk);
    rst_n <= 1;
    // directed samples with reset settings
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    drain();
    apply_setting(1);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    drain();
    apply_setting(0);
    for (int i = 0; i < 12; i++) send_sample(i[0] ? 16'h7FFF : 16'h8000);
    drain();
    // random phases: sinusoid with noise and offset, plus pure noise
    for (ph = 0; ph < 8; ph++) begin
      int amp, dc;
      real w;
      apply_setting(ph % 3 == 1 ? 1 : (ph % 3 == 2 ? 2 : 0));
      stall_on = (ph % 4 != 3);
      amp = $urandom_range(1000, 40000);
      dc = $urandom_range(0, 8000) - 4000;
      w = 0.01 + $urandom_range(0, 100) / 2000.0;
      for (int i = 0; i < 250; i++) begin
        int v;
        if ($urandom_range(0, 9) == 0) v = $urandom;
        else begin
          v = $rtoi(amp * $sin(w * i)) + dc + $urandom_range(0, 200) - 100;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end
        send_sample(v[15:0]);
      end
      drain();
    end
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sogi_pll_grid_sync_unit.f =====
rtl/core/sogi_pkg.sv
rtl/core/sogi_pll_grid_sync_unit.sv
tb/sogi_pll_grid_sync_unit_checker.sv
tb/sogi_pll_grid_sync_unit_test.sv
